// ===== sv/cea_pkg.sv =====
// ----------------------------------------------------------------------------
// cea_pkg: shared types and helpers for the instruction subset execute unit
// Holds command codes, addressing modes, writeback and result structs.
// ----------------------------------------------------------------------------
package cea_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned WordW    = 32;
  localparam int unsigned FlagW    = 5;
  localparam int unsigned SysW     = 8;
  localparam int unsigned LenW     = 3;

  // command codes
  localparam logic [2:0] CMD_EORI_SR = 3'd0;
  localparam logic [2:0] CMD_EXG     = 3'd1;
  localparam logic [2:0] CMD_EXT     = 3'd2;
  localparam logic [2:0] CMD_JMP     = 3'd3;
  localparam logic [2:0] CMD_LEA     = 3'd4;

  // effective address modes (opcode bits 5:3)
  localparam logic [2:0] MODE_AN_IND  = 3'd2;
  localparam logic [2:0] MODE_AN_D16  = 3'd5;
  localparam logic [2:0] MODE_AN_IDX  = 3'd6;
  localparam logic [2:0] MODE_SPECIAL = 3'd7;

  // register field of the special mode
  localparam logic [2:0] SPC_ABS_W   = 3'd0;
  localparam logic [2:0] SPC_ABS_L   = 3'd1;
  localparam logic [2:0] SPC_PC_D16  = 3'd2;
  localparam logic [2:0] SPC_PC_IDX  = 3'd3;
  localparam logic [2:0] SPC_IMM     = 3'd4;

  localparam logic [LenW-1:0] LEN_ONE   = 3'd2;
  localparam logic [LenW-1:0] LEN_TWO   = 3'd4;
  localparam logic [LenW-1:0] LEN_THREE = 3'd6;

  typedef logic [WordW-1:0] word_t;

  // one register write port
  typedef struct packed {
    logic               en;
    logic               is_addr;
    logic [RegIdxW-1:0] idx;
    word_t              val;
  } wb_port_t;

  // full architectural update for one instruction
  typedef struct packed {
    wb_port_t          wb0;
    wb_port_t          wb1;   // wins over wb0 on the same register
    word_t             pc;
    logic [FlagW-1:0]  flags;
    logic [SysW-1:0]   sysb;
  } state_upd_t;

  typedef struct packed {
    logic [LenW-1:0] length_bytes;
    logic            address_valid;
    word_t           eff_address;
    word_t           next_pc;
  } result_t;

  function automatic word_t sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic word_t sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

// ===== sv/cisc_ea_exg_ext_jmp_lea_unit.sv =====
// ----------------------------------------------------------------------------
// cisc_ea_exg_ext_jmp_lea_unit: execute unit for EORI SR, EXG, EXT, JMP, LEA
//
//   channel | ports           | tdata (low to high)                | tuser
//   --------+-----------------+------------------------------------+--------------
//   in      | in_t*           | opcode_word, ext_word_one/two      | command
//   out     | out_t*          | next_pc, eff_address, length_bytes | address_valid
//
// One request per cycle while the output is not stalled; a request waits in the
// input register, then its result lands in the output register while the state
// is written. The next request sees that state in the following cycle.
// Reset (rst_n low, synchronous) clears data and address registers, PC, flags,
// system byte and both pipeline stages' valid bits. A stalled output holds the
// input stage; in_tready is low only while both stages are full and out_tready is low.
// ----------------------------------------------------------------------------
module cisc_ea_exg_ext_jmp_lea_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode_word[15:0], ext_word_one[31:16], ext_word_two[47:32]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // next_pc[31:0], eff_address[63:32], length_bytes[66:64], zero
  output logic [0:0]  out_tuser   // address_valid[0]
);

  logic                      s0_valid_r;
  logic                      s0_valid_nxt;
  logic [2:0]                s0_cmd_r;
  logic [47:0]               s0_data_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  cea_pkg::result_t          out_res_r;
  logic                      advance;
  logic                      in_fire;

  cea_pkg::word_t            data_q [cea_pkg::NumRegs];
  cea_pkg::word_t            addr_q [cea_pkg::NumRegs];
  cea_pkg::word_t            pc_q;
  logic [cea_pkg::FlagW-1:0] flags_q;
  logic [cea_pkg::SysW-1:0]  sysb_q;
  cea_pkg::state_upd_t       upd;
  cea_pkg::result_t          res;

  assign advance   = s0_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s0_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    s0_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s0_valid_r);
    out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_tready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s0_valid_r  <= s0_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_cmd_r  <= in_tuser;
      s0_data_r <= in_tdata;
    end
    if (advance) out_res_r <= res;
  end

  cea_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_en  (advance),
    .upd     (upd),
    .data_q  (data_q),
    .addr_q  (addr_q),
    .pc_q    (pc_q),
    .flags_q (flags_q),
    .sysb_q  (sysb_q)
  );

  cea_exec u_exec (
    .command      (s0_cmd_r),
    .opcode_word  (s0_data_r[15:0]),
    .ext_word_one (s0_data_r[31:16]),
    .ext_word_two (s0_data_r[47:32]),
    .data_q       (data_q),
    .addr_q       (addr_q),
    .pc_q         (pc_q),
    .flags_q      (flags_q),
    .sysb_q       (sysb_q),
    .upd          (upd),
    .res          (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.length_bytes, out_res_r.eff_address,
                       out_res_r.next_pc};
  assign out_tuser  = out_res_r.address_valid;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("executed request did not reach the output register");

  a_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.length_bytes == cea_pkg::LEN_ONE ||
                     out_res_r.length_bytes == cea_pkg::LEN_TWO ||
                     out_res_r.length_bytes == cea_pkg::LEN_THREE))
    else $error("illegal instruction length");

  a_ea_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.address_valid) |-> (out_res_r.eff_address == '0))
    else $error("effective address nonzero without a valid mode");

  a_jmp_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s0_cmd_r == cea_pkg::CMD_JMP && res.address_valid) |=>
      (out_res_r.next_pc == out_res_r.eff_address && pc_q == out_res_r.next_pc))
    else $error("jump target not taken as program counter");

  a_pc_match: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (pc_q == out_res_r.next_pc))
    else $error("program counter differs from reported next_pc");

endmodule

// ===== sv/cea_regfile.sv =====
// ----------------------------------------------------------------------------
// cea_regfile: architectural state
// Data and address registers, program counter, flags and system byte.
// ----------------------------------------------------------------------------
module cea_regfile (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             upd_en,
  input  cea_pkg::state_upd_t              upd,
  output cea_pkg::word_t                   data_q [cea_pkg::NumRegs],
  output cea_pkg::word_t                   addr_q [cea_pkg::NumRegs],
  output cea_pkg::word_t                   pc_q,
  output logic [cea_pkg::FlagW-1:0]        flags_q,
  output logic [cea_pkg::SysW-1:0]         sysb_q
);

  cea_pkg::word_t              data_r [cea_pkg::NumRegs];
  cea_pkg::word_t              addr_r [cea_pkg::NumRegs];
  cea_pkg::word_t              pc_r;
  logic [cea_pkg::FlagW-1:0]   flags_r;
  logic [cea_pkg::SysW-1:0]    sysb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < cea_pkg::NumRegs; i++) begin
        data_r[i] <= '0;
        addr_r[i] <= '0;
      end
      pc_r    <= '0;
      flags_r <= '0;
      sysb_r  <= '0;
    end else if (upd_en) begin
      pc_r    <= upd.pc;
      flags_r <= upd.flags;
      sysb_r  <= upd.sysb;
      if (upd.wb0.en) begin
        if (upd.wb0.is_addr) addr_r[upd.wb0.idx] <= upd.wb0.val;
        else                 data_r[upd.wb0.idx] <= upd.wb0.val;
      end
      // second port last so it wins a clash
      if (upd.wb1.en) begin
        if (upd.wb1.is_addr) addr_r[upd.wb1.idx] <= upd.wb1.val;
        else                 data_r[upd.wb1.idx] <= upd.wb1.val;
      end
    end
  end

  assign data_q  = data_r;
  assign addr_q  = addr_r;
  assign pc_q    = pc_r;
  assign flags_q = flags_r;
  assign sysb_q  = sysb_r;

endmodule

// ===== sv/cea_exec.sv =====
// ----------------------------------------------------------------------------
// cea_exec: single-pass instruction execute
// Decodes one request, forms the effective address and the state update.
// ----------------------------------------------------------------------------
module cea_exec (
  input  logic [2:0]                       command,
  input  logic [15:0]                      opcode_word,
  input  logic [15:0]                      ext_word_one,
  input  logic [15:0]                      ext_word_two,
  input  cea_pkg::word_t                   data_q [cea_pkg::NumRegs],
  input  cea_pkg::word_t                   addr_q [cea_pkg::NumRegs],
  input  cea_pkg::word_t                   pc_q,
  input  logic [cea_pkg::FlagW-1:0]        flags_q,
  input  logic [cea_pkg::SysW-1:0]         sysb_q,
  output cea_pkg::state_upd_t              upd,
  output cea_pkg::result_t                 res
);

  logic [2:0]                  mode;
  logic [2:0]                  rx;
  logic [2:0]                  ry;
  logic [2:0]                  ix_reg;
  cea_pkg::word_t              ix_raw;
  cea_pkg::word_t              ix_val;
  cea_pkg::word_t              pc_base;
  cea_pkg::word_t              ea;
  logic                        ea_ok;
  logic [cea_pkg::LenW-1:0]    ea_len;
  cea_pkg::word_t              dy;

  assign mode   = opcode_word[5:3];
  assign rx     = opcode_word[11:9];
  assign ry     = opcode_word[2:0];
  assign ix_reg = ext_word_one[14:12];
  assign dy     = data_q[ry];
  assign pc_base = pc_q + cea_pkg::word_t'(2);

  // index term of the d8 modes
  always_comb begin
    ix_raw = ext_word_one[15] ? addr_q[ix_reg] : data_q[ix_reg];
    if (!ext_word_one[11]) ix_raw = cea_pkg::sext16(ix_raw[15:0]);
    ix_val = ix_raw + cea_pkg::sext8(ext_word_one[7:0]);
  end

  always_comb begin
    ea     = '0;
    ea_ok  = 1'b0;
    ea_len = cea_pkg::LEN_ONE;
    unique case (mode)
      cea_pkg::MODE_AN_IND: begin
        ea    = addr_q[ry];
        ea_ok = 1'b1;
      end
      cea_pkg::MODE_AN_D16: begin
        ea     = addr_q[ry] + cea_pkg::sext16(ext_word_one);
        ea_ok  = 1'b1;
        ea_len = cea_pkg::LEN_TWO;
      end
      cea_pkg::MODE_AN_IDX: begin
        ea     = addr_q[ry] + ix_val;
        ea_ok  = 1'b1;
        ea_len = cea_pkg::LEN_TWO;
      end
      cea_pkg::MODE_SPECIAL: begin
        unique case (ry)
          cea_pkg::SPC_ABS_W: begin
            ea     = cea_pkg::sext16(ext_word_one);
            ea_ok  = 1'b1;
            ea_len = cea_pkg::LEN_TWO;
          end
          cea_pkg::SPC_ABS_L: begin
            ea     = {ext_word_one, ext_word_two};
            ea_ok  = 1'b1;
            ea_len = cea_pkg::LEN_THREE;
          end
          cea_pkg::SPC_PC_D16: begin
            ea     = pc_base + cea_pkg::sext16(ext_word_one);
            ea_ok  = 1'b1;
            ea_len = cea_pkg::LEN_TWO;
          end
          cea_pkg::SPC_PC_IDX: begin
            ea     = pc_base + ix_val;
            ea_ok  = 1'b1;
            ea_len = cea_pkg::LEN_TWO;
          end
          cea_pkg::SPC_IMM: ea_len = cea_pkg::LEN_TWO;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    upd       = '0;
    upd.flags = flags_q;
    upd.sysb  = sysb_q;
    upd.pc    = pc_q + cea_pkg::word_t'(cea_pkg::LEN_ONE);
    res       = '0;
    res.length_bytes = cea_pkg::LEN_ONE;
    unique case (command)
      cea_pkg::CMD_EORI_SR: begin
        upd.flags = flags_q ^ ext_word_one[4:0];
        upd.sysb  = sysb_q ^ ext_word_one[15:8];
        upd.pc    = pc_q + cea_pkg::word_t'(cea_pkg::LEN_TWO);
        res.length_bytes = cea_pkg::LEN_TWO;
      end
      cea_pkg::CMD_EXG: begin
        upd.wb0.en = 1'b1;
        upd.wb1.en = 1'b1;
        if (opcode_word[7]) begin
          upd.wb0 = '{en: 1'b1, is_addr: 1'b0, idx: rx, val: addr_q[ry]};
          upd.wb1 = '{en: 1'b1, is_addr: 1'b1, idx: ry, val: data_q[rx]};
        end else if (opcode_word[3]) begin
          upd.wb0 = '{en: 1'b1, is_addr: 1'b1, idx: rx, val: addr_q[ry]};
          upd.wb1 = '{en: 1'b1, is_addr: 1'b1, idx: ry, val: addr_q[rx]};
        end else begin
          upd.wb0 = '{en: 1'b1, is_addr: 1'b0, idx: rx, val: data_q[ry]};
          upd.wb1 = '{en: 1'b1, is_addr: 1'b0, idx: ry, val: data_q[rx]};
        end
      end
      cea_pkg::CMD_EXT: begin
        upd.wb0.en      = 1'b1;
        upd.wb0.is_addr = 1'b0;
        upd.wb0.idx     = ry;
        upd.wb0.val     = opcode_word[6] ? cea_pkg::sext16(dy[15:0])
                                         : {dy[31:16], {8{dy[7]}}, dy[7:0]};
      end
      cea_pkg::CMD_JMP: begin
        upd.pc = ea_ok ? ea : pc_q + cea_pkg::word_t'(ea_len);
        res.eff_address   = ea;
        res.address_valid = ea_ok;
        res.length_bytes  = ea_len;
      end
      cea_pkg::CMD_LEA: begin
        upd.wb0.en      = ea_ok;
        upd.wb0.is_addr = 1'b1;
        upd.wb0.idx     = rx;
        upd.wb0.val     = ea;
        upd.pc          = pc_q + cea_pkg::word_t'(ea_len);
        res.eff_address   = ea;
        res.address_valid = ea_ok;
        res.length_bytes  = ea_len;
      end
      default: ;
    endcase
    res.next_pc = upd.pc;
  end

endmodule
